// File: hw/rtl/gdd_pkg.sv
// Package for the Gregorian date difference block.
// Holds field widths, the controller state and command types, and the
// month tables used by the datapath.
package gdd_pkg;

    // Field widths of the item ports.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;

    // An ordinal day number of a 14-bit year fits in 23 bits.
    localparam int ORD_W   = 23;
    // Quotient of a 14-bit value by 100 fits in 8 bits.
    localparam int Q100_W  = 8;
    // Days before a month, at most 334.
    localparam int CUM_W   = 9;
    // Width of the constant reciprocal product and its shift.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = YEAR_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_100  = RECIP_W'(5243);
    localparam logic [ORD_W-1:0]   YEAR_DAYS  = ORD_W'(365);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_Y,
        ST_DIV_P,
        ST_ACC,
        ST_ORD,
        ST_SUB,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;   // capture the input item
        logic side;      // 0 works on the start date, 1 on the end date
        logic div_y;     // year divided by 100
        logic div_p;     // previous year divided by 100, leap flag
        logic acc;       // days of all whole years before this one
        logic ord;       // add month and day, check the date
        logic sub;       // difference of the two ordinals
        logic load_out;  // load the output register
    } t_dp_cmd;

    // Days before the first of month m in a common year.
    function automatic logic [CUM_W-1:0] month_cum(input logic [MONTH_W-1:0] m);
        logic [CUM_W-1:0] v;
        unique case (m)
            4'd1:    v = CUM_W'(0);
            4'd2:    v = CUM_W'(31);
            4'd3:    v = CUM_W'(59);
            4'd4:    v = CUM_W'(90);
            4'd5:    v = CUM_W'(120);
            4'd6:    v = CUM_W'(151);
            4'd7:    v = CUM_W'(181);
            4'd8:    v = CUM_W'(212);
            4'd9:    v = CUM_W'(243);
            4'd10:   v = CUM_W'(273);
            4'd11:   v = CUM_W'(304);
            4'd12:   v = CUM_W'(334);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Length of month m; zero for a month outside January to December.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] v;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    v = DAY_W'(30);
            4'd2:    v = leap ? DAY_W'(29) : DAY_W'(28);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/gdd_ctrl.sv
// Controller of the Gregorian date difference block.
// Sequences the datapath through both dates and owns both handshakes.
// Depends on gdd_pkg.
module gdd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output gdd_pkg::t_dp_cmd  o_cmd
);
    import gdd_pkg::*;

    t_state r_state, n_state;
    logic   r_side, n_side;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // The output register can take a new item when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_DIV_Y;
            ST_DIV_Y: n_state = ST_DIV_P;
            ST_DIV_P: n_state = ST_ACC;
            ST_ACC:   n_state = ST_ORD;
            ST_ORD:   n_state = r_side ? ST_SUB : ST_DIV_Y;
            ST_SUB:   n_state = ST_EMIT;
            ST_EMIT:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Date side and output valid flag.
    always_comb begin
        n_side      = (r_state == ST_ORD) ? !r_side : r_side;
        n_out_valid = r_out_valid && i_out_stall;
        if (r_state == ST_EMIT && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd          = '0;
        o_cmd.side     = r_side;
        o_cmd.load_in  = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.div_y    = (r_state == ST_DIV_Y);
        o_cmd.div_p    = (r_state == ST_DIV_P);
        o_cmd.acc      = (r_state == ST_ACC);
        o_cmd.ord      = (r_state == ST_ORD);
        o_cmd.sub      = (r_state == ST_SUB);
        o_cmd.load_out = (r_state == ST_EMIT) && out_free;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_side      <= n_side;
            r_out_valid <= n_out_valid;
        end
    end

    // An accepted item always starts with the start date.
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_DIV_Y && !r_side))
        else $error("item accepted but walk did not start on the start date");

    // A result appears only out of the emit state.
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EMIT))
        else $error("output valid rose outside the emit state");

    // The end date is only worked on inside the per-date steps.
    a_side_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_side |-> (r_state == ST_DIV_Y || r_state == ST_DIV_P ||
                    r_state == ST_ACC || r_state == ST_ORD))
        else $error("end-date side selected outside the date steps");

endmodule

// File: hw/rtl/gdd_dp.sv
// Datapath of the Gregorian date difference block.
// Ordinal day numbers of both dates, validity checks, difference and output.
// Depends on gdd_pkg.
module gdd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gdd_pkg::t_dp_cmd              i_cmd,
    input  logic [gdd_pkg::YEAR_W-1:0]    i_start_year,
    input  logic [gdd_pkg::MONTH_W-1:0]   i_start_month,
    input  logic [gdd_pkg::DAY_W-1:0]     i_start_day,
    input  logic [gdd_pkg::YEAR_W-1:0]    i_end_year,
    input  logic [gdd_pkg::MONTH_W-1:0]   i_end_month,
    input  logic [gdd_pkg::DAY_W-1:0]     i_end_day,
    input  logic                          i_include_end,
    output logic [gdd_pkg::COUNT_W-1:0]   o_day_count,
    output logic                          o_input_error
);
    import gdd_pkg::*;

    // Captured item.
    logic [YEAR_W-1:0]  r_sy, r_ey;
    logic [MONTH_W-1:0] r_sm, r_em;
    logic [DAY_W-1:0]   r_sd, r_ed;
    logic               r_inc;

    // Working registers.
    logic [Q100_W-1:0]  r_qy, r_qp;
    logic               r_leap;
    logic [ORD_W-1:0]   r_acc;
    logic [ORD_W-1:0]   r_ord_a, r_ord_b;
    logic               r_err;
    logic [ORD_W-1:0]   r_diff;

    // Output register.
    logic [COUNT_W-1:0] r_count;
    logic               r_err_out;

    // Selected date.
    logic [YEAR_W-1:0]  y, p;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [PROD_W-1:0]  prod;
    logic [YEAR_W:0]    q100_x100;
    logic               leap;
    logic [ORD_W-1:0]   year_days;
    logic [YEAR_W-1:0]  leap_days;
    logic [DAY_W-1:0]   len;
    logic               bad;
    logic [ORD_W-1:0]   ord;
    logic [ORD_W:0]     sum;

    assign y = i_cmd.side ? r_ey : r_sy;
    assign m = i_cmd.side ? r_em : r_sm;
    assign d = i_cmd.side ? r_ed : r_sd;
    assign p = (y == '0) ? '0 : y - YEAR_W'(1);

    // One constant multiplier divides the year or the previous year by 100.
    assign prod = PROD_W'(i_cmd.div_y ? y : p) * PROD_W'(RECIP_100);

    // Leap rule from the year and its quotient by 100.
    assign q100_x100 = (YEAR_W+1)'(r_qy) * (YEAR_W+1)'(100);
    always_comb begin
        if (q100_x100 == {1'b0, y}) begin
            leap = (r_qy[1:0] == 2'b00);
        end else begin
            leap = (y[1:0] == 2'b00);
        end
    end

    // Days in all years before y.
    assign year_days = ORD_W'(y) * YEAR_DAYS;
    assign leap_days = (p >> 2) - YEAR_W'(r_qp) + YEAR_W'(r_qp >> 2) + YEAR_W'(1);

    // Month and day, with the date check.
    assign len = month_len(m, r_leap);
    assign bad = (len == '0) || (d == '0) || (d > len);
    assign ord = r_acc + ORD_W'(month_cum(m)) + ORD_W'(d)
               + ORD_W'(r_leap && (m > MONTH_FEB));

    assign sum = {1'b0, r_diff} + (ORD_W+1)'(r_inc);

    // Input capture and per-date steps.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sy  <= i_start_year;
            r_sm  <= i_start_month;
            r_sd  <= i_start_day;
            r_ey  <= i_end_year;
            r_em  <= i_end_month;
            r_ed  <= i_end_day;
            r_inc <= i_include_end;
        end
        if (i_cmd.div_y) begin
            r_qy <= prod[PROD_W-1:RECIP_SHIFT];
        end
        if (i_cmd.div_p) begin
            r_qp   <= prod[PROD_W-1:RECIP_SHIFT];
            r_leap <= leap;
        end
        if (i_cmd.acc) begin
            r_acc <= (y == '0) ? year_days : year_days + ORD_W'(leap_days);
        end
        if (i_cmd.ord) begin
            if (i_cmd.side) begin
                r_ord_b <= ord;
            end else begin
                r_ord_a <= ord;
            end
        end
        if (i_cmd.sub) begin
            r_diff <= (r_ord_a < r_ord_b) ? r_ord_b - r_ord_a : '0;
        end
    end

    // Error flag collects the checks of both dates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (i_cmd.load_in) begin
            r_err <= 1'b0;
        end else if (i_cmd.ord && bad) begin
            r_err <= 1'b1;
        end
    end

    // Output register: saturated count, zero on error.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_err_out <= r_err;
            if (r_err) begin
                r_count <= '0;
            end else if (sum > (ORD_W+1)'(COUNT_MAX)) begin
                r_count <= COUNT_MAX;
            end else begin
                r_count <= sum[COUNT_W-1:0];
            end
        end
    end

    assign o_day_count   = r_count;
    assign o_input_error = r_err_out;

    // An item flagged as invalid carries a zero count.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.load_out) && r_err_out |-> (r_count == '0))
        else $error("invalid item produced a nonzero day count");

endmodule

// File: hw/rtl/gregorian_date_difference_days.sv
// Top level of the Gregorian date difference block.
// Joins the controller and the datapath. Depends on gdd_pkg, gdd_ctrl, gdd_dp.
//
// Usage:
//   Input channel: i_in_valid with o_in_stall. An item (two dates and the
//   include-end flag) is taken at a clock edge with i_in_valid high and
//   o_in_stall low. Output channel: o_out_valid with i_out_stall; the day
//   count and error flag are taken at an edge with o_out_valid high and
//   i_out_stall low.
//   Sequence: the controller works on one item at a time: four datapath
//   steps per date (two divisions by 100 on one constant multiplier, the
//   year sum, the month and day sum), one subtract and one output load.
//   A new item is taken only once the last one has left the emit step
//   and the controller is back in idle.
//   Stall: a finished result waits in the output register. The block then
//   takes and works the next item, and holds it in the emit step until the
//   output register is free.
//   Reset: synchronous, active low; the controller returns to idle and the
//   output register is emptied. No clearing pass is needed.
module gregorian_date_difference_days (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gdd_pkg::YEAR_W-1:0]    i_start_year,
    input  logic [gdd_pkg::MONTH_W-1:0]   i_start_month,
    input  logic [gdd_pkg::DAY_W-1:0]     i_start_day,
    input  logic [gdd_pkg::YEAR_W-1:0]    i_end_year,
    input  logic [gdd_pkg::MONTH_W-1:0]   i_end_month,
    input  logic [gdd_pkg::DAY_W-1:0]     i_end_day,
    input  logic                          i_include_end,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gdd_pkg::COUNT_W-1:0]   o_day_count,
    output logic                          o_input_error
);
    import gdd_pkg::*;

    t_dp_cmd cmd;

    // Sequencer and handshakes.
    gdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Arithmetic and output register.
    gdd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_start_year  (i_start_year),
        .i_start_month (i_start_month),
        .i_start_day   (i_start_day),
        .i_end_year    (i_end_year),
        .i_end_month   (i_end_month),
        .i_end_day     (i_end_day),
        .i_include_end (i_include_end),
        .o_day_count   (o_day_count),
        .o_input_error (o_input_error)
    );

endmodule
